[rtl/emg_tdf_pkg.sv]
// Package for the EMG time-domain feature extractor.
// Holds the request item types and the controller/datapath command and status groups.
// No dependencies.
`default_nettype none

package emg_tdf_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned MeanW   = 24;
  localparam int unsigned WaveW   = 34;
  localparam int unsigned CountW  = 10;
  localparam int unsigned RmsW    = 24;
  localparam int unsigned TotalW  = 11;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic [MeanW-1:0]  mean_abs;
    logic [WaveW-1:0]  wave_length;
    logic [CountW-1:0] zero_crossings;
    logic [CountW-1:0] slope_changes;
    logic [RmsW-1:0]   root_mean_square;
    logic [TotalW-1:0] sample_total;
    logic              overlong;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_square;
    logic mean_capture;
    logic sqrt_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic window_done;
    logic div_done;
    logic sqrt_done;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/emg_tdf_div.sv]
// Serial restoring divider: one quotient bit per cycle.
// Used by the datapath for the window means; no package dependency.
`default_nettype none

module emg_tdf_div #(
  parameter int unsigned NumW = 59,
  parameter int unsigned DenW = 11
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] dividend_i,
  input  wire logic [DenW-1:0] divisor_i,
  output logic      [NumW-1:0] quotient_o,
  output logic                 done_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [NumW-1:0]  work_q, work_d;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [DenW:0]    rem_sh;
  logic [DenW:0]    rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, work_q[NumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(NumW);
      work_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      work_d = {work_q[NumW-2:0], ge};
      rem_d  = ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign quotient_o = work_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

[rtl/emg_tdf_isqrt.sv]
// Serial integer square root, one root bit per cycle (digit by digit).
// Used by the datapath for the RMS feature; no package dependency.
`default_nettype none

module emg_tdf_isqrt #(
  parameter int unsigned RootW = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*RootW-1:0] value_i,
  output logic      [RootW-1:0]   root_o,
  output logic                    done_o
);

  localparam int unsigned StepW = $clog2(RootW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [2*RootW-1:0] val_q, val_d;
  logic [RootW:0]     rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [RootW+2:0]   rem_sh;
  logic [RootW+2:0]   trial;
  logic [RootW+2:0]   rem_sub;
  logic               ge;

  assign rem_sh  = {rem_q, val_q[2*RootW-1:2*RootW-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(RootW);
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[2*RootW-3:0], 2'b00};
      rem_d  = ge ? rem_sub[RootW:0] : rem_sh[RootW:0];
      root_d = {root_q[RootW-2:0], ge};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[rtl/emg_tdf_datapath.sv]
// Datapath: three-stage accumulation pipeline, shared divider, square root and result register.
// Depends on emg_tdf_pkg, emg_tdf_div and emg_tdf_isqrt.
`default_nettype none

module emg_tdf_datapath #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire emg_tdf_pkg::dp_cmd_t   cmd_i,
  output emg_tdf_pkg::dp_status_t     status_o,
  input  wire emg_tdf_pkg::in_item_t  in_data_i,
  output emg_tdf_pkg::out_item_t      out_data_o
);

  import emg_tdf_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW = SB + 1;
  localparam int unsigned AW = SB + CW;
  localparam int unsigned DW = SB + 1 + CW;
  localparam int unsigned PW = 2 * SB;
  localparam int unsigned QW = 2 * SB + CW;

  logic signed [SB-1:0] x_s;
  logic [SB-1:0]        ax_s;

  logic                 v1_q, last1_q;
  logic signed [SB-1:0] x1_q;
  logic [SB-1:0]        ax1_q;

  logic                 v2_q, last2_q, last3_q;
  logic [PW-1:0]        sq2_q;
  logic [SW-1:0]        dsl2_q;

  logic [CW-1:0]        cnt_q;
  logic signed [SB-1:0] prev_q;
  logic signed [SW-1:0] pslope_q;
  logic [AW-1:0]        abs_acc_q;
  logic [DW-1:0]        diff_acc_q;
  logic [QW-1:0]        sq_acc_q;
  logic [CW-1:0]        zc_q;
  logic [CW-1:0]        sc_q;
  logic                 ovf_q;

  logic                 take_s;
  logic signed [SW-1:0] slope_s;
  logic [SW-1:0]        aslope_s;
  logic [PW-1:0]        prod_s;
  logic                 x_pos, x_neg, p_pos, p_neg;
  logic                 s_pos, s_neg, ps_pos, ps_neg;
  logic                 cross_s, turn_s;

  logic [QW-1:0]        dividend_s;
  logic [QW-1:0]        quot_s;
  logic                 div_done_s;
  logic [SB-1:0]        root_s;
  logic                 sqrt_done_s;
  logic [SB-1:0]        mean_q;
  out_item_t            out_q;

  assign x_s  = in_data_i.sample[SB-1:0];
  assign ax_s = x_s[SB-1] ? (~x_s + SB'(1)) : x_s;

  assign take_s   = v1_q && (cnt_q < CW'(WINDOW_MAX));
  assign slope_s  = {x1_q[SB-1], x1_q} - {prev_q[SB-1], prev_q};
  assign aslope_s = slope_s[SW-1] ? (~slope_s + SW'(1)) : slope_s;
  assign prod_s   = PW'(ax1_q) * PW'(ax1_q);

  assign x_neg   = x1_q[SB-1];
  assign x_pos   = !x1_q[SB-1] && (x1_q != '0);
  assign p_neg   = prev_q[SB-1];
  assign p_pos   = !prev_q[SB-1] && (prev_q != '0);
  assign s_neg   = slope_s[SW-1];
  assign s_pos   = !slope_s[SW-1] && (slope_s != '0);
  assign ps_neg  = pslope_q[SW-1];
  assign ps_pos  = !pslope_q[SW-1] && (pslope_q != '0);
  assign cross_s = (x_pos && p_neg) || (x_neg && p_pos);
  assign turn_s  = (s_pos && ps_neg) || (s_neg && ps_pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
    end else begin
      v1_q    <= cmd_i.load;
      last1_q <= cmd_i.load && in_data_i.last_sample;
      v2_q    <= take_s;
      last2_q <= v1_q && last1_q;
      last3_q <= last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q  <= x_s;
      ax1_q <= ax_s;
    end
    if (take_s) begin
      sq2_q  <= prod_s;
      dsl2_q <= (cnt_q != '0) ? aslope_s : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_q     <= '0;
      pslope_q   <= '0;
      abs_acc_q  <= '0;
      diff_acc_q <= '0;
      sq_acc_q   <= '0;
      zc_q       <= '0;
      sc_q       <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.out_load) begin
      cnt_q      <= '0;
      prev_q     <= '0;
      pslope_q   <= '0;
      abs_acc_q  <= '0;
      diff_acc_q <= '0;
      sq_acc_q   <= '0;
      zc_q       <= '0;
      sc_q       <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (v1_q && !take_s) begin
        ovf_q <= 1'b1;
      end
      if (take_s) begin
        abs_acc_q <= abs_acc_q + AW'(ax1_q);
        prev_q    <= x1_q;
        cnt_q     <= cnt_q + CW'(1);
        if (cnt_q != '0) begin
          pslope_q <= slope_s;
          if (cross_s) begin
            zc_q <= zc_q + CW'(1);
          end
          if ((cnt_q != CW'(1)) && turn_s) begin
            sc_q <= sc_q + CW'(1);
          end
        end
      end
      if (v2_q) begin
        sq_acc_q   <= sq_acc_q + QW'(sq2_q);
        diff_acc_q <= diff_acc_q + DW'(dsl2_q);
      end
    end
  end

  assign dividend_s = cmd_i.div_sel_square ? sq_acc_q : QW'(abs_acc_q);

  emg_tdf_div #(
    .NumW (QW),
    .DenW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend_s),
    .divisor_i  (cnt_q),
    .quotient_o (quot_s),
    .done_o     (div_done_s)
  );

  emg_tdf_isqrt #(
    .RootW (SB)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (quot_s[PW-1:0]),
    .root_o  (root_s),
    .done_o  (sqrt_done_s)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_capture) begin
      mean_q <= quot_s[SB-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.mean_abs         <= MeanW'(mean_q);
      out_q.wave_length      <= WaveW'(diff_acc_q);
      out_q.zero_crossings   <= CountW'(zc_q);
      out_q.slope_changes    <= CountW'(sc_q);
      out_q.root_mean_square <= RmsW'(root_s);
      out_q.sample_total     <= TotalW'(cnt_q);
      out_q.overlong         <= ovf_q;
    end
  end

  assign out_data_o           = out_q;
  assign status_o.window_done = last3_q;
  assign status_o.div_done    = div_done_s;
  assign status_o.sqrt_done   = sqrt_done_s;

endmodule

`default_nettype wire

[rtl/emg_tdf_ctrl.sv]
// Controller: sequences sample intake, the closing divides and square root, and the result hand-off.
// Depends on emg_tdf_pkg.
`default_nettype none

module emg_tdf_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_last_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output emg_tdf_pkg::dp_cmd_t         cmd_o,
  input  wire emg_tdf_pkg::dp_status_t status_i
);

  import emg_tdf_pkg::*;

  localparam logic [3:0] StRun    = 4'd0;
  localparam logic [3:0] StDrain  = 4'd1;
  localparam logic [3:0] StDivAGo = 4'd2;
  localparam logic [3:0] StDivA   = 4'd3;
  localparam logic [3:0] StDivSGo = 4'd4;
  localparam logic [3:0] StDivS   = 4'd5;
  localparam logic [3:0] StSqrtGo = 4'd6;
  localparam logic [3:0] StSqrt   = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StRun: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (status_i.window_done) begin
          state_d = StDivAGo;
        end
      end
      StDivAGo: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDivA;
      end
      StDivA: begin
        if (status_i.div_done) begin
          cmd_o.mean_capture = 1'b1;
          state_d            = StDivSGo;
        end
      end
      StDivSGo: begin
        cmd_o.div_start      = 1'b1;
        cmd_o.div_sel_square = 1'b1;
        state_d              = StDivS;
      end
      StDivS: begin
        if (status_i.div_done) begin
          state_d = StSqrtGo;
        end
      end
      StSqrtGo: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = StSqrt;
      end
      StSqrt: begin
        if (status_i.sqrt_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StRun;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StRun);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/emg_time_domain_features.sv]
// Top level of the EMG time-domain feature extractor (MAV, WL, ZC, SSC, RMS).
// Depends on emg_tdf_pkg, emg_tdf_ctrl and emg_tdf_datapath.
//
//   Channel  Direction  Handshake                Payload
//   in       request    in_valid_i / in_stall_o   in_data_i  (emg_tdf_pkg::in_item_t)
//   out      result     out_valid_o / out_stall_i out_data_o (emg_tdf_pkg::out_item_t)
//
// Samples inside a window are taken one per cycle.
// The last sample closes the window: two divides of 2*SAMPLE_BITS+CW quotient bits each on the
// shared serial divider (CW = clog2(WINDOW_MAX+1)), then a SAMPLE_BITS-bit square root, plus
// pipeline drain, start-up and hand-off; no input is taken meanwhile.
// A result still held in the output register delays the hand-off until it is taken.
// A finished result waits in the output register while the next window is taken.
// Reset clears all window state at once; no clearing pass follows it.
`default_nettype none

module emg_time_domain_features #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire emg_tdf_pkg::in_item_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output emg_tdf_pkg::out_item_t      out_data_o
);

  import emg_tdf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  emg_tdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_sample),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  emg_tdf_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for emg_time_domain_features: drives sample requests, predicts each
// window's features in SystemVerilog and compares every result field by field.
// Depends on emg_tdf_pkg and the emg_time_domain_features RTL.
`timescale 1ns / 100ps

module tb_top;
  import emg_tdf_pkg::*;

  localparam int unsigned WindowMax = 1024;
  localparam int MaxSample = (1 << (SampleW - 1)) - 1;
  localparam int MinSample = -(1 << (SampleW - 1));

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  in_item_t  sample_requests[$];
  out_item_t expected_features[$];
  int        requested_count = 0;
  int        mismatch_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;
  logic      receiver_hold = 1'b0;
  int        last_value = 0;

  int unsigned     window_count = 0;
  longint          prev_sample = 0;
  longint          prev_slope = 0;
  longint unsigned abs_sum = 0;
  longint unsigned diff_sum = 0;
  longint unsigned square_sum = 0;
  int unsigned     crossing_count = 0;
  int unsigned     slope_change_count = 0;
  bit              window_overflow = 1'b0;

  emg_time_domain_features #(
    .WINDOW_MAX (WindowMax),
    .SAMPLE_BITS(SampleW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit signs_differ(input longint a, input longint b);
    return (a > 0 && b < 0) || (a < 0 && b > 0);
  endfunction

  task automatic accumulate_features(input in_item_t item);
    longint          x;
    longint          slope;
    longint unsigned mean_square;
    longint unsigned root;
    longint unsigned trial;
    out_item_t       features;
    x = $signed(item.sample);
    if (window_count >= WindowMax) begin
      window_overflow = 1'b1;
    end else begin
      abs_sum += magnitude(x);
      square_sum += magnitude(x) * magnitude(x);
      if (window_count >= 1) begin
        slope = x - prev_sample;
        diff_sum += magnitude(slope);
        if (signs_differ(x, prev_sample)) crossing_count++;
        if (window_count >= 2 && signs_differ(slope, prev_slope)) slope_change_count++;
        prev_slope = slope;
      end
      prev_sample = x;
      window_count++;
    end
    if (item.last_sample) begin
      mean_square = square_sum / window_count;
      root = 0;
      for (int b = 24; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= mean_square) root = trial;
      end
      features.mean_abs         = MeanW'(abs_sum / window_count);
      features.wave_length      = WaveW'(diff_sum);
      features.zero_crossings   = CountW'(crossing_count);
      features.slope_changes    = CountW'(slope_change_count);
      features.root_mean_square = RmsW'(root);
      features.sample_total     = TotalW'(window_count);
      features.overlong         = window_overflow;
      expected_features.push_back(features);
      window_count       = 0;
      prev_sample        = 0;
      prev_slope         = 0;
      abs_sum            = 0;
      diff_sum           = 0;
      square_sum         = 0;
      crossing_count     = 0;
      slope_change_count = 0;
      window_overflow    = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic push_request(input int value, input bit last);
    in_item_t item;
    item.sample      = value[SampleW-1:0];
    item.last_sample = last;
    sample_requests.push_back(item);
    last_value = $signed(item.sample);
    requested_count++;
  endtask

  task automatic add_random_window();
    int len;
    int value;
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0: value = $urandom_range(1) ? MaxSample : MinSample;
        1: value = 0;
        2, 3: value = int'($urandom_range(8)) - 4;
        4: value = last_value;
        5: value = -last_value;
        default: value = $urandom;
      endcase
      push_request(value, i == len - 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) accumulate_features(in_data_i);
      if (sample_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= sample_requests.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : feature_monitor
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_features.size() == 0) begin
          $error("result received with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_features.pop_front();
          compare_field("mean_abs", want.mean_abs, out_data_o.mean_abs);
          compare_field("wave_length", want.wave_length, out_data_o.wave_length);
          compare_field("zero_crossings", want.zero_crossings, out_data_o.zero_crossings);
          compare_field("slope_changes", want.slope_changes, out_data_o.slope_changes);
          compare_field("root_mean_square", want.root_mean_square,
                        out_data_o.root_mean_square);
          compare_field("sample_total", want.sample_total, out_data_o.sample_total);
          compare_field("overlong", want.overlong, out_data_o.overlong);
        end
      end
      out_stall_i <= receiver_hold || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_request(MaxSample, 1'b1);
    push_request(MinSample, 1'b1);
    push_request(0, 1'b1);
    push_request(5, 1'b0);
    push_request(-3, 1'b0);
    push_request(0, 1'b0);
    push_request(4, 1'b0);
    push_request(4, 1'b0);
    push_request(-2, 1'b1);
    push_request(0, 1'b0);
    push_request(0, 1'b0);
    push_request(0, 1'b1);
    push_request(MinSample, 1'b0);
    push_request(MaxSample, 1'b1);
    for (int i = 0; i < 5; i++) push_request((i % 2) ? -1 : 1, i == 4);
    while (sample_requests.size() != 0) @(posedge clk_i);

    fork
      begin
        receiver_hold <= 1'b1;
        repeat (400) @(posedge clk_i);
        receiver_hold <= 1'b0;
      end
    join_none
    target = requested_count + 50;
    while (requested_count < target) add_random_window();
    while (sample_requests.size() != 0) @(posedge clk_i);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
        2: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
        default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
      target = requested_count + 95;
      while (requested_count < target) add_random_window();
      while (sample_requests.size() != 0) @(posedge clk_i);
    end

    while (in_valid_i) @(posedge clk_i);
    while (expected_features.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (expected_features.size() != 0) begin
      $error("%0d expected results never arrived", expected_features.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
